@@ design/tlik_pkg.sv @@
// Package for the two-link leg IK core: widths, status codes, CORDIC table.
// No dependencies.
package tlik_pkg;
  localparam int CordicSteps = 18;
  localparam int SqrtSteps   = 19;
  localparam int SqW         = 2 * SqrtSteps;
  localparam int RootW       = SqrtSteps;
  localparam int AngW        = 28;
  localparam int VecW        = 40;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REACH  = 2'd1,
    ST_ABOVE  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  function automatic logic signed [AngW-1:0] atan_lut(input int i);
    logic signed [AngW-1:0] r;
    case (i)
      0: r = 28'sd2949120;   1: r = 28'sd1740967;   2: r = 28'sd919879;
      3: r = 28'sd466945;    4: r = 28'sd234379;    5: r = 28'sd117304;
      6: r = 28'sd58666;     7: r = 28'sd29335;     8: r = 28'sd14668;
      9: r = 28'sd7334;     10: r = 28'sd3667;     11: r = 28'sd1833;
      12: r = 28'sd917;     13: r = 28'sd458;      14: r = 28'sd229;
      15: r = 28'sd115;     16: r = 28'sd57;       17: r = 28'sd29;
      default: r = '0;
    endcase
    return r;
  endfunction
endpackage

@@ design/tlik_isqrt_stage.sv @@
// One digit step of the pipelined floor square root (radix 2, one root bit per step).
// Depends on tlik_pkg.
module tlik_isqrt_stage import tlik_pkg::*; (
  input  logic             clk,
  input  logic             en,
  input  logic [4:0]       step,
  input  logic [SqW-1:0]   rem_i,
  input  logic [RootW-1:0] root_i,
  output logic [SqW-1:0]   rem_o,
  output logic [RootW-1:0] root_o
);
  logic [SqW+1:0]   trial;
  logic [SqW+1:0]   cur;
  logic [5:0]       sh;
  logic [SqW-1:0]   rem_r;
  logic [RootW-1:0] root_r;
  logic [SqW-1:0]   rem_nxt;
  logic [RootW-1:0] root_nxt;

  assign sh = 6'(2 * (SqrtSteps - 1 - int'(step)));

  always_comb begin
    cur   = {2'b00, rem_i} >> sh;
    trial = (SqW+2)'({root_i, 2'b01});
    if (cur >= trial) begin
      rem_nxt  = rem_i - SqW'(trial << sh);
      root_nxt = {root_i[RootW-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_i;
      root_nxt = {root_i[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

  assign rem_o  = rem_r;
  assign root_o = root_r;
endmodule

@@ design/tlik_cordic_stage.sv @@
// One vectoring CORDIC iteration with its register.
// Depends on tlik_pkg.
module tlik_cordic_stage import tlik_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [4:0]             step,
  input  logic signed [VecW-1:0] x_i,
  input  logic signed [VecW-1:0] y_i,
  input  logic signed [AngW-1:0] z_i,
  output logic signed [VecW-1:0] x_o,
  output logic signed [VecW-1:0] y_o,
  output logic signed [AngW-1:0] z_o
);
  logic signed [VecW-1:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [AngW-1:0] z_r, z_nxt;

  always_comb begin
    if (y_i > 0) begin
      x_nxt = x_i + (y_i >>> step);
      y_nxt = y_i - (x_i >>> step);
      z_nxt = z_i + atan_lut(int'(step));
    end else begin
      x_nxt = x_i - (y_i >>> step);
      y_nxt = y_i + (x_i >>> step);
      z_nxt = z_i - atan_lut(int'(step));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;
endmodule

@@ design/two_link_leg_inverse_kinematics_core.sv @@
// Two-link leg inverse kinematics core, fully pipelined.
// Depth: 42 register stages. Throughput: one transfer per cycle unless stalled.
// Stages: square/limit (2), two isqrt chains (19),
// two CORDIC chains (18), finish (3, the last one is the output register).
// A held result (out_tvalid && !out_tready) freezes the whole pipeline and in_tready.
// rst_n synchronous active low clears valid bits and sets segment_length 1648.
module two_link_leg_inverse_kinematics_core import tlik_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata,      // segment_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,       // [12:0] foot_x, [25:13] foot_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata       // [14:0] hip, [28:15] knee, [30:29] status
);
  localparam int Depth = 2 + SqrtSteps + CordicSteps + 3;

  logic [11:0] seg_r;
  logic        en;
  logic [Depth-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) seg_r <= 12'd1648;
    else if (cfg_we) seg_r <= cfg_wdata;
  end

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[Depth-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[Depth-1];

  // stage 0: squares
  logic signed [12:0] x0_r, y0_r;
  logic [25:0] q0_r;
  logic [25:0] lim0_r;
  logic signed [12:0] fx, fy;
  logic signed [25:0] fxe, fye;
  logic [25:0] seg2;
  assign fx   = in_tdata[12:0];
  assign fy   = in_tdata[25:13];
  assign fxe  = 26'(fx);
  assign fye  = 26'(fy);
  assign seg2 = 26'({seg_r, 1'b0});
  always_ff @(posedge clk) begin
    if (en) begin
      x0_r   <= fx;
      y0_r   <= fy;
      q0_r   <= $unsigned(fxe * fxe) + $unsigned(fye * fye);
      lim0_r <= seg2 * seg2;
    end
  end

  // stage 1: compare and sqrt operands
  logic signed [12:0] x1_r, y1_r;
  status_t st1_r;
  logic [SqW-1:0] sa1_r, sb1_r;
  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= x0_r;
      y1_r  <= y0_r;
      sa1_r <= {q0_r, 12'd0};
      sb1_r <= {lim0_r - q0_r, 12'd0};
      if (!y0_r[12]) st1_r <= ST_ABOVE;
      else if (q0_r > lim0_r) st1_r <= ST_REACH;
      else st1_r <= ST_OK;
    end
  end

  // isqrt chains with side data
  logic [SqW-1:0] ra [SqrtSteps+1];
  logic [SqW-1:0] rb [SqrtSteps+1];
  logic [RootW-1:0] oa [SqrtSteps+1];
  logic [RootW-1:0] ob [SqrtSteps+1];
  logic signed [12:0] sx [SqrtSteps+1];
  logic signed [12:0] sy [SqrtSteps+1];
  status_t ss [SqrtSteps+1];
  assign ra[0] = sa1_r;
  assign rb[0] = sb1_r;
  assign oa[0] = '0;
  assign ob[0] = '0;
  assign sx[0] = x1_r;
  assign sy[0] = y1_r;
  assign ss[0] = st1_r;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq
    tlik_isqrt_stage u_a (
      .clk, .en, .step(5'(g)), .rem_i(ra[g]), .root_i(oa[g]),
      .rem_o(ra[g+1]), .root_o(oa[g+1])
    );
    tlik_isqrt_stage u_b (
      .clk, .en, .step(5'(g)), .rem_i(rb[g]), .root_i(ob[g]),
      .rem_o(rb[g+1]), .root_o(ob[g+1])
    );
    logic signed [12:0] sx_r, sy_r;
    status_t ss_r;
    always_ff @(posedge clk) begin
      if (en) begin
        sx_r <= sx[g];
        sy_r <= sy[g];
        ss_r <= ss[g];
      end
    end
    assign sx[g+1] = sx_r;
    assign sy[g+1] = sy_r;
    assign ss[g+1] = ss_r;
  end

  // two CORDIC chains: arc (a) and foot direction (b)
  logic signed [VecW-1:0] ax [CordicSteps+1];
  logic signed [VecW-1:0] ay [CordicSteps+1];
  logic signed [AngW-1:0] az [CordicSteps+1];
  logic signed [VecW-1:0] bx [CordicSteps+1];
  logic signed [VecW-1:0] by [CordicSteps+1];
  logic signed [AngW-1:0] bz [CordicSteps+1];
  status_t cs [CordicSteps+1];
  logic signed [12:0] sxl, syl;
  assign sxl = sx[SqrtSteps];
  assign syl = sy[SqrtSteps];
  assign ax[0] = VecW'({ob[SqrtSteps], 8'd0});
  assign ay[0] = VecW'({oa[SqrtSteps], 8'd0});
  assign az[0] = '0;
  assign bx[0] = VecW'(-VecW'(syl)) <<< 16;
  assign by[0] = VecW'(sxl) <<< 16;
  assign bz[0] = '0;
  assign cs[0] = ss[SqrtSteps];

  for (genvar g = 0; g < CordicSteps; g++) begin : g_co
    tlik_cordic_stage u_a (
      .clk, .en, .step(5'(g)), .x_i(ax[g]), .y_i(ay[g]), .z_i(az[g]),
      .x_o(ax[g+1]), .y_o(ay[g+1]), .z_o(az[g+1])
    );
    tlik_cordic_stage u_b (
      .clk, .en, .step(5'(g)), .x_i(bx[g]), .y_i(by[g]), .z_i(bz[g]),
      .x_o(bx[g+1]), .y_o(by[g+1]), .z_o(bz[g+1])
    );
    status_t cs_r;
    always_ff @(posedge clk) begin
      if (en) cs_r <= cs[g];
    end
    assign cs[g+1] = cs_r;
  end

  // finish stage 1: sums
  localparam logic signed [AngW-1:0] Deg90  = 28'sd5898240;
  localparam logic signed [AngW-1:0] Deg180 = 28'sd11796480;
  logic signed [AngW-1:0] a_sel, kn_r, hp_r;
  status_t f1_r;
  assign a_sel = (cs[CordicSteps] == ST_REACH) ? Deg90 : az[CordicSteps];
  always_ff @(posedge clk) begin
    if (en) begin
      kn_r <= Deg180 - (a_sel <<< 1) + 28'sd512;
      hp_r <= Deg90 - a_sel + bz[CordicSteps] + 28'sd512;
      f1_r <= cs[CordicSteps];
    end
  end

  // finish stage 2: scale
  logic signed [17:0] kn2_r, hp2_r;
  status_t f2_r;
  always_ff @(posedge clk) begin
    if (en) begin
      kn2_r <= kn_r[27:10];
      hp2_r <= hp_r[27:10];
      f2_r  <= f1_r;
    end
  end

  // finish stage 3: clamp and pack
  logic [14:0] hip_nxt;
  logic [13:0] kn_nxt;
  logic [31:0] out_r;
  always_comb begin
    if (hp2_r < -18'sd5760) hip_nxt = 15'(-18'sd5760);
    else if (hp2_r > 18'sd11520) hip_nxt = 15'd11520;
    else hip_nxt = hp2_r[14:0];
    if (kn2_r < 18'sd0) kn_nxt = '0;
    else if (kn2_r > 18'sd11520) kn_nxt = 14'd11520;
    else kn_nxt = kn2_r[13:0];
    if (f2_r == ST_REACH) kn_nxt = '0;
    if (f2_r == ST_ABOVE) begin
      hip_nxt = '0;
      kn_nxt  = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (en) out_r <= {1'b0, f2_r, kn_nxt, hip_nxt};
  end
  assign out_tdata = out_r;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid) else $error("result lost in stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready)) else $error("ready mismatch");
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[30:29] != ST_UNUSED) else $error("bad status");
endmodule
